>>> design/cnf_formula_checker_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the CNF formula checker
// ---------------------------------------------------------------------------
`ifndef CNF_FORMULA_CHECKER_TOP_DEFINES_SVH
`define CNF_FORMULA_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CFC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CFC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cfc_pkg.sv
// ---------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants of the CNF formula checker.
// ---------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

  localparam int MAX_CLAUSES = 256;
  localparam int NUM_VARS    = 64;
  localparam int IDX_W       = $clog2(MAX_CLAUSES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int VAR_W       = 6;
  localparam int S_TDATA_W   = 96;
  localparam int M_TDATA_W   = 24;

  // Item kind carried in s_axis_tuser
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_CHECK = 1'b1
  } cfc_op_e;

  // One literal: variable number in the low bits, negation above it
  typedef struct packed {
    logic             neg;
    logic [VAR_W-1:0] vnum;
  } cfc_lit_t;

  // One stored clause, first literal in the low bits
  typedef struct packed {
    cfc_lit_t third;
    cfc_lit_t second;
    cfc_lit_t first;
  } cfc_clause_t;

  // Input tdata layout, first field lowest
  typedef struct packed {
    logic [2:0]       pad;
    logic [63:0]      assignment;
    logic             third_neg;
    logic [VAR_W-1:0] third_var;
    logic             second_neg;
    logic [VAR_W-1:0] second_var;
    logic             first_neg;
    logic [VAR_W-1:0] first_var;
    logic [7:0]       clause_index;
  } cfc_s_data_t;

  // Output tdata layout, first field lowest
  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] first_failing;
    logic [8:0] failing_count;
    logic       all_satisfied;
  } cfc_m_data_t;

endpackage

`default_nettype wire

>>> design/cfc_clause_eval.sv
// ---------------------------------------------------------------------------
// cfc_clause_eval
// Tests one clause against a variable assignment: true if any literal holds.
// ---------------------------------------------------------------------------
`default_nettype none

module cfc_clause_eval
  import cfc_pkg::*;
(
  input  cfc_clause_t clause_i,
  input  logic [63:0] assign_i,
  output logic        sat_o
);

  // Look up one literal; a variable beyond the assignment reads as false
  function automatic logic lit_true(cfc_lit_t lit, logic [63:0] asg);
    logic val;
    val = 1'b0;
    if ({1'b0, lit.vnum} < 7'(NUM_VARS)) begin
      val = asg[lit.vnum];
    end
    return lit.neg ^ val;
  endfunction

  assign sat_o = lit_true(clause_i.first,  assign_i)
               | lit_true(clause_i.second, assign_i)
               | lit_true(clause_i.third,  assign_i);

endmodule

`default_nettype wire

>>> design/cnf_formula_checker_top.sv
// ---------------------------------------------------------------------------
// cnf_formula_checker_top
// Clause table for 3-literal CNF formulas with a sequential satisfaction check.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries items; tuser selects load (0) or check (1). A load writes
//   one clause into the table slot clause_index. A check brings a 64-bit
//   assignment and walks slots 0 .. min(clause_count, 256) - 1.
//   m_axis returns one transfer per item; tuser is 1 for a check answer and
//   0 for a load acknowledge (whose tdata is all zero).
//   cfg_we_i writes clause_count from cfg_wdata_i; write it only while idle.
// Sequencing:
//   A load goes from the idle state to the emit state, where its acknowledge
//   is posted. A check with N = min(clause_count, 256) above 0 first walks:
//   N table reads are issued at one per cycle, and each clause is evaluated
//   as its registered read data returns; it then posts from the emit state.
//   With N = 0 it runs like a load. The clause RAM has a single read port.
// Reset and stalls:
//   Reset clears clause_count and the control state; the table holds no
//   defined contents until slots are loaded, and no clearing pass is run.
//   The output register holds a result while m_axis_tready is low; the next
//   item is still accepted and worked on, and waits only to post its result.
// ---------------------------------------------------------------------------
`default_nettype none

module cnf_formula_checker_top
  import cfc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: clause_count
  input  logic                 cfg_we_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] clause_index, [13:8] first_var, [14] first_neg, [20:15] second_var,
  // [21] second_neg, [27:22] third_var, [28] third_neg, [92:29] assignment
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] opcode
  input  logic [0:0]           s_axis_tuser,
  // Output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] all_satisfied, [9:1] failing_count, [17:10] first_failing
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] is_check_result
  output logic [0:0]           m_axis_tuser
);

  `include "cnf_formula_checker_top_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } cfc_state_e;

  cfc_state_e state_q, state_d;

  cfc_s_data_t in_data;
  cfc_op_e     in_op;
  logic        in_xfer;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] lim_q, lim_d, count_sat;
  logic [CNT_W-1:0] iss_q;
  logic             rd_en;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [63:0]      asg_q;
  logic             chk_q;
  logic [CNT_W-1:0] fail_q;
  logic [IDX_W-1:0] first_q;
  logic             clause_sat;
  logic             out_free;

  cfc_clause_t      mem_q [MAX_CLAUSES];
  cfc_clause_t      rd_data_q;
  cfc_clause_t      wr_data;

  logic                 m_valid_q;
  cfc_m_data_t          m_data_q;
  logic                 m_user_q;

  assign in_data = cfc_s_data_t'(s_axis_tdata);
  assign in_op   = cfc_op_e'(s_axis_tuser[0]);

  // Take items only between jobs; the table is never read and written at once
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  // Saturate the active clause count to the table depth
  assign count_sat = (count_q > CNT_W'(MAX_CLAUSES)) ? CNT_W'(MAX_CLAUSES) : count_q;
  assign lim_d     = count_sat;

  // Issue one table read per cycle until all active slots are requested
  assign rd_en = (state_q == ST_WALK) && (iss_q != lim_q);

  assign wr_data.first  = '{neg: in_data.first_neg,  vnum: in_data.first_var};
  assign wr_data.second = '{neg: in_data.second_neg, vnum: in_data.second_var};
  assign wr_data.third  = '{neg: in_data.third_neg,  vnum: in_data.third_var};

  // Hold the clause count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Clause RAM: write on load transfer, registered read during a walk
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_op == OP_LOAD) begin
      mem_q[in_data.clause_index] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[iss_q[IDX_W-1:0]];
    end
  end

  cfc_clause_eval u_eval (
    .clause_i (rd_data_q),
    .assign_i (asg_q),
    .sat_o    (clause_sat)
  );

  // Sequence load, walk and result posting
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_CHECK && lim_d != '0) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        if (!rd_en && rd_vld_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      iss_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (in_xfer) begin
        iss_q <= '0;
      end else if (rd_en) begin
        iss_q <= iss_q + 1'b1;
      end
    end
  end

  // Capture the job and accumulate failures as read data returns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q   <= 1'b0;
      fail_q  <= '0;
      first_q <= '0;
      lim_q   <= '0;
    end else if (in_xfer) begin
      chk_q   <= (in_op == OP_CHECK);
      fail_q  <= '0;
      first_q <= '0;
      lim_q   <= lim_d;
    end else if (rd_vld_q && !clause_sat) begin
      if (fail_q == '0) begin
        first_q <= rd_idx_q;
      end
      fail_q <= fail_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      asg_q <= in_data.assignment;
    end
    rd_idx_q <= iss_q[IDX_W-1:0];
  end

  // Output register: post the result, drop valid once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      m_user_q               <= chk_q;
      m_data_q.pad           <= '0;
      m_data_q.all_satisfied <= chk_q & (fail_q == '0);
      m_data_q.failing_count <= fail_q;
      m_data_q.first_failing <= first_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = M_TDATA_W'(m_data_q);
  assign m_axis_tuser[0] = m_user_q;

  // Checks
  `CFC_ASSERT_IMP(a_fail_bound, state_q != ST_IDLE, fail_q <= lim_q,
    "failure count exceeds active clause count")
  `CFC_ASSERT_IMP(a_rd_in_range, rd_vld_q, CNT_W'(rd_idx_q) < lim_q,
    "clause read beyond active range")
  `CFC_ASSERT_NXT(a_emit_hold, state_q == ST_EMIT && m_valid_q && !m_axis_tready,
    state_q == ST_EMIT, "result posted over a stalled output")
  `CFC_ASSERT_IMP(a_sat_consistent, m_valid_q && m_user_q,
    m_data_q.all_satisfied == (m_data_q.failing_count == '0),
    "all_satisfied disagrees with failing_count")
  `CFC_ASSERT_IMP(a_ack_zero, m_valid_q && !m_user_q, m_data_q == '0,
    "load acknowledge carries nonzero data")

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Stream-level test of the CNF formula checker: clause loads and assignment
// checks are driven with random idling on both sides. A scoreboard keeps a
// shadow clause table and predicts each load acknowledge and check verdict.
// ---------------------------------------------------------------------------
`default_nettype none

import cfc_pkg::*;

// One predicted result transfer
typedef struct packed {
  logic             is_check;
  logic             all_sat;
  logic [CNT_W-1:0] fail_count;
  logic [IDX_W-1:0] first_fail;
} verdict_t;

class formula_scoreboard;
  cfc_clause_t      clause_table [MAX_CLAUSES];
  logic [CNT_W-1:0] clause_count;
  verdict_t         pending_verdicts [$];
  int               errors;

  function new();
    clause_count = '0;
    errors       = 0;
    foreach (clause_table[i]) clause_table[i] = '0;
  endfunction

  function void set_count(logic [CNT_W-1:0] value);
    clause_count = value;
  endfunction

  function int pending_count();
    return pending_verdicts.size();
  endfunction

  // A variable outside the assignment reads as false
  function bit literal_holds(cfc_lit_t lit, logic [63:0] assign_bits);
    bit val;
    val = 1'b0;
    if (int'(lit.vnum) < NUM_VARS) val = assign_bits[lit.vnum];
    return val ^ lit.neg;
  endfunction

  function bit clause_holds(cfc_clause_t c, logic [63:0] assign_bits);
    return literal_holds(c.first, assign_bits) || literal_holds(c.second, assign_bits) ||
           literal_holds(c.third, assign_bits);
  endfunction

  // Update the shadow table or evaluate the formula for one accepted transfer
  function void note_item(cfc_op_e op, cfc_s_data_t d);
    verdict_t    v;
    cfc_clause_t c;
    int          n;
    int          fails;
    int          first_bad;
    v = '0;
    if (op == OP_LOAD) begin
      c.first.vnum  = d.first_var;
      c.first.neg   = d.first_neg;
      c.second.vnum = d.second_var;
      c.second.neg  = d.second_neg;
      c.third.vnum  = d.third_var;
      c.third.neg   = d.third_neg;
      if (int'(d.clause_index) < MAX_CLAUSES) clause_table[d.clause_index] = c;
    end else begin
      n         = (int'(clause_count) > MAX_CLAUSES) ? MAX_CLAUSES : int'(clause_count);
      fails     = 0;
      first_bad = 0;
      for (int i = 0; i < n; i++) begin
        if (!clause_holds(clause_table[i], d.assignment)) begin
          if (fails == 0) first_bad = i;
          fails++;
        end
      end
      v.is_check   = 1'b1;
      v.all_sat    = (fails == 0);
      v.fail_count = CNT_W'(fails);
      v.first_fail = IDX_W'(first_bad);
    end
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Match one result transfer against the oldest prediction
  function void check_result(logic user, logic [M_TDATA_W-1:0] raw);
    verdict_t    want;
    cfc_m_data_t got;
    got = raw;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: result with none expected, expected nothing actual tuser %0h tdata %0h",
               $time, user, raw);
      errors++;
    end else begin
      want = pending_verdicts.pop_front();
      compare_field("is_check_result", 32'(want.is_check), 32'(user));
      compare_field("all_satisfied", 32'(want.all_sat), 32'(got.all_satisfied));
      compare_field("failing_count", 32'(want.fail_count), 32'(got.failing_count));
      compare_field("first_failing", 32'(want.first_fail), 32'(got.first_failing));
    end
  endfunction
endclass

module testbench;

  localparam int TOTAL_ITEMS    = 1200;
  localparam int CALM_ITEMS     = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 400;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CNT_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  formula_scoreboard sb;
  int                items_sent = 0;
  bit                no_idle    = 1'b0;
  bit                calm       = 1'b0;
  bit                hold_req   = 1'b0;
  bit                hold_done  = 1'b0;

  cnf_formula_checker_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock, period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand_assignment();
    return {$urandom, $urandom};
  endfunction

  function automatic cfc_lit_t rand_literal();
    cfc_lit_t lit;
    lit.vnum = VAR_W'($urandom_range(0, NUM_VARS - 1));
    lit.neg  = 1'($urandom_range(0, 1));
    return lit;
  endfunction

  function automatic cfc_clause_t rand_clause();
    cfc_clause_t c;
    c.first  = rand_literal();
    c.second = rand_literal();
    c.third  = rand_literal();
    return c;
  endfunction

  // Draw a clause that holds (or fails) under the given assignment
  function automatic cfc_clause_t clause_for(logic [63:0] assign_bits, bit want_true);
    cfc_clause_t c;
    c = rand_clause();
    if (want_true) begin
      if (!sb.clause_holds(c, assign_bits)) begin
        case ($urandom_range(0, 2))
          0:       c.first.neg  = ~c.first.neg;
          1:       c.second.neg = ~c.second.neg;
          default: c.third.neg  = ~c.third.neg;
        endcase
      end
    end else begin
      c.first.neg  = assign_bits[c.first.vnum];
      c.second.neg = assign_bits[c.second.vnum];
      c.third.neg  = assign_bits[c.third.vnum];
    end
    return c;
  endfunction

  function automatic cfc_s_data_t pack_item(logic [IDX_W-1:0] idx, cfc_clause_t c,
                                            logic [63:0] assign_bits);
    cfc_s_data_t d;
    d              = '0;
    d.clause_index = idx;
    d.first_var    = c.first.vnum;
    d.first_neg    = c.first.neg;
    d.second_var   = c.second.vnum;
    d.second_neg   = c.second.neg;
    d.third_var    = c.third.vnum;
    d.third_neg    = c.third.neg;
    d.assignment   = assign_bits;
    return d;
  endfunction

  // Offer one item from a falling edge; return at the falling edge after the transfer
  task automatic send_item(cfc_op_e op, cfc_s_data_t d);
    if (!no_idle && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_item(op, d);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_clause(logic [IDX_W-1:0] idx, cfc_clause_t c);
    send_item(OP_LOAD, pack_item(idx, c, rand_assignment()));
  endtask

  task automatic check_assignment(logic [63:0] assign_bits);
    send_item(OP_CHECK, pack_item(IDX_W'($urandom), rand_clause(), assign_bits));
  endtask

  // Drop valid and wait for every predicted result
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    drain();
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_count(value);
  endtask

  // Receiver: short random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser[0], m_axis_tdata);
  end

  // Watchdog: count cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    logic [63:0]      plant;
    logic [63:0]      probe;
    logic [CNT_W-1:0] cnt;
    cfc_clause_t      c;
    int               n;
    int               reps;
    int               bit_pos;
    bit               planted;
    sb            = new();
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    plant         = '0;
    n             = 0;
    cnt           = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty formula, then a few hand-made clauses
    write_count('0);
    check_assignment('0);
    check_assignment('1);
    load_clause(IDX_W'(0), '0);
    load_clause(IDX_W'(1), cfc_clause_t'({3{7'h7F}}));
    c.first.neg   = 1'b1;
    c.first.vnum  = VAR_W'(0);
    c.second.neg  = 1'b0;
    c.second.vnum = VAR_W'(63);
    c.third.neg   = 1'b0;
    c.third.vnum  = VAR_W'(31);
    load_clause(IDX_W'(2), c);
    c.first.neg   = 1'b1;
    c.first.vnum  = VAR_W'(63);
    c.second      = c.first;
    c.third.neg   = 1'b0;
    c.third.vnum  = VAR_W'(0);
    load_clause(IDX_W'(MAX_CLAUSES - 1), c);
    check_assignment('0);

    write_count(CNT_W'(3));
    check_assignment('0);
    check_assignment('1);
    check_assignment(64'h1 << 63);
    check_assignment(64'h1);
    write_count(CNT_W'(1));
    check_assignment('0);
    check_assignment(64'h1);

    // Fill the whole table with one clause; all slots fail or all hold
    c.first.neg  = 1'b0;
    c.first.vnum = VAR_W'(5);
    c.second     = c.first;
    c.third      = c.first;
    for (int i = 0; i < MAX_CLAUSES; i++) load_clause(IDX_W'(i), c);
    write_count(CNT_W'(MAX_CLAUSES));
    check_assignment('0);
    check_assignment(64'h20);
    write_count('1);
    check_assignment('0);
    check_assignment('1);

    // Random rounds: planted-solution formulas and free mixes
    while (items_sent < TOTAL_ITEMS) begin
      no_idle = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
      calm    = ($urandom_range(0, 4) == 0);
      planted = ($urandom_range(0, 9) < 6);
      if (planted) begin
        case ($urandom_range(0, 9))
          7, 8:    n = $urandom_range(25, MAX_CLAUSES - 1);
          9:       n = MAX_CLAUSES;
          default: n = $urandom_range(1, 24);
        endcase
        cnt = (n == MAX_CLAUSES && $urandom_range(0, 1) == 1) ?
              CNT_W'($urandom_range(MAX_CLAUSES, 511)) : CNT_W'(n);
        plant = rand_assignment();
      end else begin
        case ($urandom_range(0, 5))
          0:       cnt = '0;
          1:       cnt = CNT_W'(1);
          2:       cnt = CNT_W'(MAX_CLAUSES);
          3:       cnt = '1;
          default: cnt = CNT_W'($urandom_range(0, 511));
        endcase
      end
      write_count(cnt);
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (planted) begin
        for (int i = 0; i < n; i++) load_clause(IDX_W'(i), clause_for(plant, 1'b1));
        reps = $urandom_range(3, 10);
        repeat (reps) begin
          case ($urandom_range(0, 3))
            0: check_assignment(plant);
            1: begin
              probe = plant;
              repeat ($urandom_range(1, 3)) begin
                bit_pos        = $urandom_range(0, 63);
                probe[bit_pos] = ~probe[bit_pos];
              end
              check_assignment(probe);
            end
            2: begin
              // Break one active slot, then ask for the planted solution again
              load_clause(IDX_W'($urandom_range(0, n - 1)), clause_for(plant, 1'b0));
              check_assignment(plant);
            end
            default: check_assignment(rand_assignment());
          endcase
        end
      end else begin
        reps = $urandom_range(10, 40);
        repeat (reps) begin
          if ($urandom_range(0, 9) < 4) load_clause(IDX_W'($urandom), rand_clause());
          else check_assignment(rand_assignment());
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> cnf_formula_checker_top.f
+incdir+design
design/cfc_pkg.sv
design/cfc_clause_eval.sv
design/cnf_formula_checker_top.sv
verif/testbench.sv
